FILE: src/ema_coefficient_of_variation_assert.svh
// Assertion macros shared by the coefficient of variation RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef EMA_COEFFICIENT_OF_VARIATION_ASSERT_SVH
`define EMA_COEFFICIENT_OF_VARIATION_ASSERT_SVH
`ifndef SYNTHESIS
`define ECV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ECV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ECV_ASSERT(label, clk, rst, prop, msg)
`define ECV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/ecv_pkg.sv
// Shared constants, register indexes and unit status type for the
// coefficient of variation block. No dependencies.
package ecv_pkg;

   localparam int ENERGY_W    = 16;
   localparam int ALPHA_W     = 16;
   localparam int WARMUP_W    = 8;
   localparam int CV_W        = 16;
   localparam int CV_SHIFT    = 14;
   localparam int QUOT_W      = 17;
   localparam int ROUND_SHIFT = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP = 4'd1;

   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd2570;
   localparam logic [WARMUP_W-1:0] WARMUP_RESET = 8'd125;
   localparam logic [WARMUP_W-1:0] WARMUP_MAX   = 8'd255;
   localparam logic [ALPHA_W:0]    ONE_ALPHA    = 17'h10000;
   localparam logic [CV_W-1:0]     CV_LIMIT     = 16'h8000;

   typedef struct packed {
      logic busy;
      logic done;
   } ecv_unit_status_type;

endpackage

FILE: src/ecv_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ecv_pkg and the assertion macro header.
`include "ema_coefficient_of_variation_assert.svh"
module ecv_mul
   import ecv_pkg::*;
#(
   parameter int A_W = 49,
   parameter int B_W = 33
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [A_W-1:0]         operand_a,
   input  logic [B_W-1:0]         operand_b,
   output logic [A_W+B_W-1:0]     product,
   output ecv_unit_status_type    status
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]   mcand_ff, mcand_in;
   logic [P_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [A_W:0]     psum;

   always_comb begin
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      psum     = {1'b0, prod_ff[P_W-1:B_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         mcand_in = operand_a;
         prod_in  = {{A_W{1'b0}}, operand_b};
         cnt_in   = CNT_W'(B_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {psum, prod_ff[B_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   always_comb begin
      status.busy = busy_ff;
      status.done = done_ff;
   end

   assign product = prod_ff;

   `ECV_ASSERT(a_mul_start_idle, clock, reset, start |-> !busy_ff, "multiply started while busy")
   `ECV_ASSERT(a_mul_done_clean, clock, reset, done_ff |-> !busy_ff && cnt_ff == '0, "bad done")
   `ECV_ASSERT_NEXT(a_mul_runs, clock, reset, busy_ff && cnt_ff != CNT_W'(1), busy_ff, "early stop")

endmodule

FILE: src/ecv_sqrt.sv
// Digit-serial square root, two radicand bits per cycle, of var * 2^FRAC_BITS.
// Depends on ecv_pkg.
module ecv_sqrt
   import ecv_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [FRAC_BITS+31:0]     operand,
   output logic [FRAC_BITS+15:0]     root,
   output ecv_unit_status_type       status
);

   localparam int VW    = FRAC_BITS + 32;
   localparam int RW    = FRAC_BITS + 16;
   localparam int RADW  = 2 * RW;
   localparam int REMW  = RW + 3;
   localparam int CNT_W = $clog2(RW + 1);

   logic [RADW-1:0]  rad_ff, rad_in;
   logic [REMW-1:0]  rem_ff, rem_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REMW-1:0]  rem_sh;
   logic [REMW-1:0]  trial;
   logic             fits;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REMW-3:0], rad_ff[RADW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = rem_sh >= trial;
      if (start) begin
         rad_in  = {operand[VW-1:0], {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RADW-3:0], 2'b00};
         rem_in  = fits ? rem_sh - trial : rem_sh;
         root_in = {root_ff[RW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   always_comb begin
      status.busy = busy_ff;
      status.done = done_ff;
   end

   assign root = root_ff;

endmodule

FILE: src/ecv_div.sv
// Restoring divider, one quotient bit per cycle, for sigma * 2^14 / mean,
// with the quotient clamped to 2.0 in Q2.14. Depends on ecv_pkg.
module ecv_div
   import ecv_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [FRAC_BITS+15:0]  sigma,
   input  logic [FRAC_BITS+16:0]  den,
   output logic [CV_W-1:0]        quot,
   output ecv_unit_status_type    status
);

   localparam int RW    = FRAC_BITS + 16;
   localparam int DENW  = FRAC_BITS + 17;
   localparam int NUMW  = RW + CV_SHIFT;
   localparam int DVSW  = DENW + QUOT_W - 1;
   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [NUMW-1:0]   rem_ff, rem_in;
   logic [DVSW-1:0]   dvs_ff, dvs_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              ovf;
   logic              ge;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf     = {4'b0000, sigma} >= {den, 3'b000};
      ge      = {{(DVSW-NUMW){1'b0}}, rem_ff} >= dvs_ff;
      if (start) begin
         if (ovf) begin
            q_in    = QUOT_W'(CV_LIMIT);
            done_in = 1'b1;
         end else begin
            rem_in  = {sigma, {CV_SHIFT{1'b0}}};
            dvs_in  = {den, {(QUOT_W-1){1'b0}}};
            q_in    = '0;
            cnt_in  = CNT_W'(QUOT_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - dvs_ff[NUMW-1:0] : rem_ff;
         dvs_in = dvs_ff >> 1;
         q_in   = {q_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end

   always_comb begin
      status.busy = busy_ff;
      status.done = done_ff;
   end

   assign quot = (q_ff > QUOT_W'(CV_LIMIT)) ? CV_LIMIT : q_ff[CV_W-1:0];

endmodule

FILE: src/ema_coefficient_of_variation.sv
// Coefficient of variation of a stream of frame energies. Each accepted word updates an
// exponential moving mean and variance and returns one result word: 0 with tuser low while
// warming up, otherwise sqrt(var)/mean in Q2.14, 0 when the mean is at most 1.0 and clamped
// to 2.0. Every item takes four passes through the bit-serial multiplier; after warmup,
// when the mean is above 1.0, the square root at two radicand bits per cycle and the
// divider follow. One item is in work at a time; a finished word waits in the output
// register while the next item is taken.
// Depends on ecv_pkg, ecv_mul, ecv_sqrt, ecv_div and the assertion macro header.
`include "ema_coefficient_of_variation_assert.svh"
module ema_coefficient_of_variation
   import ecv_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ENERGY_W-1:0]     req_tdata,   // [15:0] frame_energy
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [CV_W-1:0]         rsp_tdata,   // [15:0] variation
   output logic                    rsp_tuser,   // [0] ready_res
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int MW  = FRAC_BITS + 18;
   localparam int MGW = FRAC_BITS + 17;
   localparam int VW  = FRAC_BITS + 32;
   localparam int AW  = FRAC_BITS + 33;
   localparam int BW  = FRAC_BITS + 17;
   localparam int PW  = AW + BW;
   localparam int TW  = FRAC_BITS + 34;
   localparam int RW  = FRAC_BITS + 16;

   localparam logic signed [MW-1:0] MEAN_ONE = MW'(1) << FRAC_BITS;
   localparam logic [PW:0] HALF    = (PW+1)'(1) << (ROUND_SHIFT - 1);
   localparam logic [PW:0] HALF_LO = HALF - (PW+1)'(1);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SQ_GO     = 4'd1;
   localparam logic [3:0] S_SQ_WAIT   = 4'd2;
   localparam logic [3:0] S_VA_GO     = 4'd3;
   localparam logic [3:0] S_VA_WAIT   = 4'd4;
   localparam logic [3:0] S_VB_GO     = 4'd5;
   localparam logic [3:0] S_VB_WAIT   = 4'd6;
   localparam logic [3:0] S_MN_GO     = 4'd7;
   localparam logic [3:0] S_MN_WAIT   = 4'd8;
   localparam logic [3:0] S_UPDATE    = 4'd9;
   localparam logic [3:0] S_CHECK     = 4'd10;
   localparam logic [3:0] S_ROOT_WAIT = 4'd11;
   localparam logic [3:0] S_DIV_GO    = 4'd12;
   localparam logic [3:0] S_DIV_WAIT  = 4'd13;
   localparam logic [3:0] S_OUT       = 4'd14;

   logic [3:0]              state_ff, state_in;
   logic [ALPHA_W-1:0]      alpha_ff, alpha_in;
   logic [WARMUP_W-1:0]     warmup_ff, warmup_in;
   logic signed [MW-1:0]    mean_ff, mean_in;
   logic [VW-1:0]           var_ff, var_in;
   logic [WARMUP_W-1:0]     count_ff, count_in;
   logic                    valid_ff, valid_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;

   logic signed [MW-1:0]    d_ff, d_in;
   logic [AW-1:0]           sq_ff, sq_in;
   logic [TW-1:0]           t1_ff, t1_in;
   logic [TW-1:0]           t2_ff, t2_in;
   logic [MGW-1:0]          t3_ff, t3_in;
   logic [CV_W-1:0]         res_cv_ff, res_cv_in;
   logic                    res_rdy_ff, res_rdy_in;
   logic [CV_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   logic signed [MW-1:0]    xq;
   logic signed [MW-1:0]    dneg;
   logic [MGW-1:0]          mag;
   logic                    dsign;
   logic [PW:0]             rnd_bias;
   logic [PW:0]             rnd_sum;
   logic [TW-1:0]           vsum;
   logic signed [MW-1:0]    t3s;
   logic [WARMUP_W-1:0]     count_next;

   logic                    mul_start;
   logic [AW-1:0]           mul_a;
   logic [BW-1:0]           mul_b;
   logic [PW-1:0]           product;
   ecv_unit_status_type     mul_st;

   logic                    root_start;
   logic [RW-1:0]           root;
   ecv_unit_status_type     root_st;

   logic                    div_start;
   logic [CV_W-1:0]         quot;
   ecv_unit_status_type     div_st;

   ecv_mul #(
      .A_W (AW),
      .B_W (BW)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product),
      .status    (mul_st)
   );

   ecv_sqrt #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (var_ff),
      .root    (root),
      .status  (root_st)
   );

   ecv_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sigma  (root),
      .den    (mean_ff[MGW-1:0]),
      .quot   (quot),
      .status (div_st)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      xq       = $signed({{2{req_tdata[ENERGY_W-1]}}, req_tdata, {FRAC_BITS{1'b0}}});
      dsign    = d_ff[MW-1];
      dneg     = -d_ff;
      mag      = dsign ? dneg[MGW-1:0] : d_ff[MGW-1:0];
      rnd_bias = (dsign && state_ff == S_MN_WAIT) ? HALF_LO : HALF;
      rnd_sum  = {1'b0, product} + rnd_bias;
      vsum     = t1_ff + t2_ff;
      t3s      = $signed({1'b0, t3_ff});
      count_next = (count_ff == WARMUP_MAX) ? count_ff : count_ff + 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      alpha_in      = alpha_ff;
      warmup_in     = warmup_ff;
      mean_in       = mean_ff;
      var_in        = var_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      res_cv_in     = res_cv_ff;
      res_rdy_in    = res_rdy_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mul_start     = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      root_start    = 1'b0;
      div_start     = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA:  alpha_in  = csr_wdata[ALPHA_W-1:0];
            CSR_WARMUP: warmup_in = csr_wdata[WARMUP_W-1:0];
            default: ;
         endcase
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               d_in     = xq - mean_ff;
               state_in = S_SQ_GO;
            end
         end
         S_SQ_GO: begin
            mul_start = 1'b1;
            mul_a     = AW'(mag);
            mul_b     = mag;
            state_in  = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (mul_st.done) begin
               sq_in    = product[FRAC_BITS +: AW];
               state_in = S_VA_GO;
            end
         end
         S_VA_GO: begin
            mul_start = 1'b1;
            mul_a     = sq_ff;
            mul_b     = BW'(alpha_ff);
            state_in  = S_VA_WAIT;
         end
         S_VA_WAIT: begin
            if (mul_st.done) begin
               t1_in    = rnd_sum[ROUND_SHIFT +: TW];
               state_in = S_VB_GO;
            end
         end
         S_VB_GO: begin
            mul_start = 1'b1;
            mul_a     = AW'(var_ff);
            mul_b     = BW'(ONE_ALPHA - {1'b0, alpha_ff});
            state_in  = S_VB_WAIT;
         end
         S_VB_WAIT: begin
            if (mul_st.done) begin
               t2_in    = rnd_sum[ROUND_SHIFT +: TW];
               state_in = S_MN_GO;
            end
         end
         S_MN_GO: begin
            mul_start = 1'b1;
            mul_a     = AW'(mag);
            mul_b     = BW'(alpha_ff);
            state_in  = S_MN_WAIT;
         end
         S_MN_WAIT: begin
            if (mul_st.done) begin
               t3_in    = rnd_sum[ROUND_SHIFT +: MGW];
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            var_in  = (|vsum[TW-1:VW]) ? {VW{1'b1}} : vsum[VW-1:0];
            mean_in = dsign ? mean_ff - t3s : mean_ff + t3s;
            if (!valid_ff) begin
               count_in   = count_next;
               valid_in   = (count_next >= warmup_ff);
               res_cv_in  = '0;
               res_rdy_in = 1'b0;
               state_in   = S_OUT;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (mean_ff > MEAN_ONE) begin
               root_start = 1'b1;
               state_in   = S_ROOT_WAIT;
            end else begin
               res_cv_in  = '0;
               res_rdy_in = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_ROOT_WAIT: begin
            if (root_st.done) begin
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_st.done) begin
               res_cv_in  = quot;
               res_rdy_in = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = res_cv_ff;
               rsp_user_in   = res_rdy_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         alpha_ff      <= ALPHA_RESET;
         warmup_ff     <= WARMUP_RESET;
         mean_ff       <= MEAN_ONE;
         var_ff        <= '0;
         count_ff      <= '0;
         valid_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alpha_ff      <= alpha_in;
         warmup_ff     <= warmup_in;
         mean_ff       <= mean_in;
         var_ff        <= var_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      res_cv_ff   <= res_cv_in;
      res_rdy_ff  <= res_rdy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `ECV_ASSERT_NEXT(a_valid_sticky, clock, reset, valid_ff, valid_ff, "estimate valid dropped")
   `ECV_ASSERT_NEXT(a_count_frozen, clock, reset, valid_ff, $stable(count_ff), "count moved")
   `ECV_ASSERT(a_mean_range, clock, reset, mean_ff[MW-1] == mean_ff[MW-2], "mean out of range")
   `ECV_ASSERT(a_warmup_zero, clock, reset,
      rsp_tvalid_ff && !rsp_user_ff |-> rsp_data_ff == '0, "warmup word not zero")
   `ECV_ASSERT(a_cv_limit, clock, reset,
      rsp_tvalid_ff |-> rsp_data_ff <= CV_LIMIT, "variation above limit")
   `ECV_ASSERT(a_one_unit, clock, reset,
      $countones({mul_st.busy, root_st.busy, div_st.busy}) <= 1, "units overlap")

endmodule
